>>> src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that pre implies post in the same cycle
`define ASSERT_IMPL(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("same-cycle implication failed");

// check that pre implies post in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("next-cycle implication failed");

`endif

>>> src/hvpc_pkg.sv
package hvpc_pkg;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_PRE  = 2'd1,
		MODE_RUN  = 2'd2
	} mode_t;

	localparam logic [1:0] IGN_NONE = 2'd0;
	localparam logic [1:0] IGN_ON   = 2'd1;
	localparam logic [1:0] IGN_OFF  = 2'd2;

	localparam logic [2:0] SAFE_NONE     = 3'd0;
	localparam logic [2:0] SAFE_FUSE     = 3'd1;
	localparam logic [2:0] SAFE_HEATSINK = 3'd2;
	localparam logic [2:0] SAFE_BOARD    = 3'd3;
	localparam logic [2:0] SAFE_OVERVOLT = 3'd4;
	localparam logic [2:0] SAFE_NORELAY  = 3'd5;

	localparam logic [2:0] CTRL_NONE      = 3'd0;
	localparam logic [2:0] CTRL_UNDERVOLT = 3'd1;
	localparam logic [2:0] CTRL_SHORT     = 3'd2;
	localparam logic [2:0] CTRL_OVERTIME  = 3'd3;
	localparam logic [2:0] CTRL_NOBUS     = 3'd4;

	localparam int CFG_DATA_W  = 24;
	localparam int CFG_INDEX_W = 3;

	localparam logic [CFG_INDEX_W-1:0] REG_MIN_BUS     = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_GAP         = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_MIN_PRE     = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_PRE     = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_HEATSINK    = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_CIRCUIT     = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_OV_MARGIN   = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_HOLDOFF     = 3'd7;

	typedef struct packed {
		logic signed [23:0] min_bus_voltage;
		logic signed [17:0] contact_gap;
		logic [19:0]        min_precharge_ticks;
		logic [19:0]        max_precharge_ticks;
		logic signed [23:0] heatsink_limit;
		logic signed [23:0] circuit_limit;
		logic signed [23:0] overvoltage_margin;
		logic [19:0]        error_holdoff;
	} cfg_t;

	typedef struct packed {
		logic [1:0]         ignition_event;
		logic [16:0]        batt_raw;
		logic [16:0]        load_raw;
		logic signed [23:0] batt_scaled;
		logic signed [23:0] load_scaled;
		logic signed [23:0] hs_temp;
		logic signed [23:0] board_temp;
		logic               contactor_fuse_ok;
	} tick_t;

	typedef struct packed {
		logic [1:0] mode_now;
		logic       mode_changed;
		logic       relay_drive;
		logic       contactor_drive;
		logic [2:0] safety_error;
		logic [2:0] control_error;
	} status_t;

	typedef struct packed {
		mode_t mode;
		logic  latch;
		logic  relay;
		logic  contactor;
	} ctl_state_t;

endpackage

>>> src/hvpc_tick_if.sv
interface hvpc_tick_if;
	logic                valid;
	logic                ready;
	hvpc_pkg::tick_t     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> src/hvpc_status_if.sv
interface hvpc_status_if;
	logic                valid;
	logic                ready;
	hvpc_pkg::status_t   data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> src/hvpc_step.sv
module hvpc_step #(
	parameter int TIMER_WIDTH = 21
) (
	input  hvpc_pkg::cfg_t       cfg,
	input  hvpc_pkg::tick_t      tick,
	input  hvpc_pkg::ctl_state_t state,
	input  logic [TIMER_WIDTH-1:0] pre_elapsed,
	input  logic [TIMER_WIDTH-1:0] holdoff_elapsed,
	output hvpc_pkg::ctl_state_t state_nxt,
	output logic [TIMER_WIDTH-1:0] pre_elapsed_nxt,
	output logic [TIMER_WIDTH-1:0] holdoff_elapsed_nxt,
	output hvpc_pkg::status_t    result
);

	localparam int CW = (TIMER_WIDTH > 20) ? TIMER_WIDTH : 20;
	localparam logic [TIMER_WIDTH-1:0] TMAX = {TIMER_WIDTH{1'b1}};

	logic [TIMER_WIDTH-1:0] pre_inc;
	logic [TIMER_WIDTH-1:0] hold_inc;
	logic [TIMER_WIDTH-1:0] hold_after;
	logic                   latch_upd;
	logic [2:0]             safety_raw;
	logic                   safety_fire;
	logic                   hold_pass;
	logic                   hold_pass_after;
	logic signed [24:0]     ov_sum;
	logic signed [18:0]     gap_diff;
	logic                   gap_small;
	logic                   under_batt;
	logic                   under_load;
	logic                   pre_min_done;
	logic                   pre_max_done;
	logic                   changed;
	logic [2:0]             control;

	assign pre_inc  = (pre_elapsed == TMAX) ? pre_elapsed : pre_elapsed + 1'b1;
	assign hold_inc = (holdoff_elapsed == TMAX) ? holdoff_elapsed : holdoff_elapsed + 1'b1;

	always_comb begin
		case (tick.ignition_event)
			hvpc_pkg::IGN_ON:  latch_upd = 1'b1;
			hvpc_pkg::IGN_OFF: latch_upd = 1'b0;
			default:           latch_upd = state.latch;
		endcase
	end

	assign ov_sum = $signed({tick.batt_scaled[23], tick.batt_scaled})
		+ $signed({cfg.overvoltage_margin[23], cfg.overvoltage_margin});
	assign gap_diff = $signed({2'b00, tick.batt_raw}) - $signed({2'b00, tick.load_raw});
	assign gap_small = gap_diff < $signed({cfg.contact_gap[17], cfg.contact_gap});
	assign under_batt = tick.batt_scaled < cfg.min_bus_voltage;
	assign under_load = tick.load_scaled < cfg.min_bus_voltage;
	assign pre_min_done = CW'(pre_inc) >= CW'(cfg.min_precharge_ticks);
	assign pre_max_done = CW'(pre_inc) >= CW'(cfg.max_precharge_ticks);

	always_comb begin
		if (!tick.contactor_fuse_ok) begin
			safety_raw = hvpc_pkg::SAFE_FUSE;
		end else if (tick.hs_temp > cfg.heatsink_limit) begin
			safety_raw = hvpc_pkg::SAFE_HEATSINK;
		end else if (tick.board_temp > cfg.circuit_limit) begin
			safety_raw = hvpc_pkg::SAFE_BOARD;
		end else if (ov_sum <= $signed({tick.load_scaled[23], tick.load_scaled})) begin
			safety_raw = hvpc_pkg::SAFE_OVERVOLT;
		end else if (state.contactor && !state.relay) begin
			safety_raw = hvpc_pkg::SAFE_NORELAY;
		end else begin
			safety_raw = hvpc_pkg::SAFE_NONE;
		end
	end

	assign hold_pass       = CW'(hold_inc) > CW'(cfg.error_holdoff);
	assign safety_fire     = (safety_raw != hvpc_pkg::SAFE_NONE) && hold_pass;
	assign hold_after      = safety_fire ? '0 : hold_inc;
	assign hold_pass_after = CW'(hold_after) > CW'(cfg.error_holdoff);

	always_comb begin
		state_nxt           = state;
		state_nxt.latch     = latch_upd;
		pre_elapsed_nxt     = pre_inc;
		holdoff_elapsed_nxt = hold_after;
		changed             = 1'b0;
		control             = hvpc_pkg::CTRL_NONE;
		case (state.mode)
			hvpc_pkg::MODE_IDLE: begin
				if (latch_upd) begin
					if (under_batt) begin
						control         = hvpc_pkg::CTRL_UNDERVOLT;
						state_nxt.latch = 1'b0;
					end else begin
						state_nxt.relay = 1'b1;
						pre_elapsed_nxt = '0;
						state_nxt.mode  = hvpc_pkg::MODE_PRE;
						changed         = 1'b1;
					end
				end
			end
			hvpc_pkg::MODE_PRE: begin
				if (gap_small) begin
					if (pre_min_done) begin
						state_nxt.contactor = 1'b1;
						state_nxt.mode      = hvpc_pkg::MODE_RUN;
						changed             = 1'b1;
					end else begin
						control = hvpc_pkg::CTRL_SHORT;
					end
				end else if (pre_max_done && hold_pass_after) begin
					holdoff_elapsed_nxt = '0;
					control             = hvpc_pkg::CTRL_OVERTIME;
				end
				if (!latch_upd) begin
					state_nxt.relay     = 1'b0;
					state_nxt.contactor = 1'b0;
					state_nxt.mode      = hvpc_pkg::MODE_IDLE;
					changed             = 1'b1;
				end
			end
			hvpc_pkg::MODE_RUN: begin
				if (!latch_upd || (under_batt && under_load)) begin
					state_nxt.relay     = 1'b0;
					state_nxt.contactor = 1'b0;
					state_nxt.mode      = hvpc_pkg::MODE_IDLE;
					changed             = 1'b1;
				end
				if (under_batt && under_load) begin
					control = hvpc_pkg::CTRL_NOBUS;
				end
			end
			default: begin
			end
		endcase
	end

	assign result.mode_now        = state_nxt.mode;
	assign result.mode_changed    = changed;
	assign result.relay_drive     = state_nxt.relay;
	assign result.contactor_drive = state_nxt.contactor;
	assign result.safety_error    = safety_fire ? safety_raw : hvpc_pkg::SAFE_NONE;
	assign result.control_error   = control;

endmodule

>>> src/hv_precharge_controller_top.sv
// A tick passes through the input register (tick_s1) and then the result register (status_q)
// before its status transaction is offered.
// Throughput: one tick per cycle while status is taken; a waiting status holds the tick in
// the input register, and tick.ready drops until the status is taken.
// Reset: arst_n clears mode to idle, ignition latch, relay, contactor and both timers at once,
// and loads the configuration registers with their defaults.
module hv_precharge_controller_top #(
	parameter int TIMER_WIDTH = 21
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [hvpc_pkg::CFG_INDEX_W-1:0]    wr_index,
	input  logic [hvpc_pkg::CFG_DATA_W-1:0]     wr_data,
	hvpc_tick_if.sink                           tick,
	hvpc_status_if.source                       status
);

	`include "assert_macros.svh"

	hvpc_pkg::cfg_t         cfg_q;
	hvpc_pkg::tick_t        tick_s1;
	logic                   valid_s1;
	hvpc_pkg::status_t      status_q;
	logic                   out_valid_q;
	hvpc_pkg::ctl_state_t   state_q;
	hvpc_pkg::ctl_state_t   state_nxt;
	logic [TIMER_WIDTH-1:0] pre_q;
	logic [TIMER_WIDTH-1:0] holdoff_q;
	logic [TIMER_WIDTH-1:0] pre_nxt;
	logic [TIMER_WIDTH-1:0] holdoff_nxt;
	hvpc_pkg::status_t      result;
	logic                   adv;
	logic                   accept_in;

	assign adv          = valid_s1 && (!out_valid_q || status.ready);
	assign tick.ready   = !valid_s1 || adv;
	assign accept_in    = tick.valid && tick.ready;
	assign status.valid = out_valid_q;
	assign status.data  = status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_bus_voltage     <= 24'sd0;
			cfg_q.contact_gap         <= 18'sd0;
			cfg_q.min_precharge_ticks <= 20'd0;
			cfg_q.max_precharge_ticks <= 20'd1048575;
			cfg_q.heatsink_limit      <= 24'sd8388607;
			cfg_q.circuit_limit       <= 24'sd8388607;
			cfg_q.overvoltage_margin  <= 24'sd0;
			cfg_q.error_holdoff       <= 20'd1000;
		end else if (wr_en) begin
			case (wr_index)
				hvpc_pkg::REG_MIN_BUS:   cfg_q.min_bus_voltage     <= wr_data;
				hvpc_pkg::REG_GAP:       cfg_q.contact_gap         <= wr_data[17:0];
				hvpc_pkg::REG_MIN_PRE:   cfg_q.min_precharge_ticks <= wr_data[19:0];
				hvpc_pkg::REG_MAX_PRE:   cfg_q.max_precharge_ticks <= wr_data[19:0];
				hvpc_pkg::REG_HEATSINK:  cfg_q.heatsink_limit      <= wr_data;
				hvpc_pkg::REG_CIRCUIT:   cfg_q.circuit_limit       <= wr_data;
				hvpc_pkg::REG_OV_MARGIN: cfg_q.overvoltage_margin  <= wr_data;
				hvpc_pkg::REG_HOLDOFF:   cfg_q.error_holdoff       <= wr_data[19:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept_in) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			tick_s1 <= tick.data;
		end
	end

	hvpc_step #(
		.TIMER_WIDTH(TIMER_WIDTH)
	) u_step (
		.cfg                 (cfg_q),
		.tick                (tick_s1),
		.state               (state_q),
		.pre_elapsed         (pre_q),
		.holdoff_elapsed     (holdoff_q),
		.state_nxt           (state_nxt),
		.pre_elapsed_nxt     (pre_nxt),
		.holdoff_elapsed_nxt (holdoff_nxt),
		.result              (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode      <= hvpc_pkg::MODE_IDLE;
			state_q.latch     <= 1'b0;
			state_q.relay     <= 1'b0;
			state_q.contactor <= 1'b0;
			pre_q             <= '0;
			holdoff_q         <= '0;
			out_valid_q       <= 1'b0;
		end else if (adv) begin
			state_q     <= state_nxt;
			pre_q       <= pre_nxt;
			holdoff_q   <= holdoff_nxt;
			out_valid_q <= 1'b1;
		end else if (status.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status_q <= result;
		end
	end

	`ASSERT_IMPL(a_contactor_in_run, clk, arst_n, state_q.contactor, state_q.mode == hvpc_pkg::MODE_RUN)
	`ASSERT_IMPL(a_relay_not_idle, clk, arst_n, state_q.relay, state_q.mode != hvpc_pkg::MODE_IDLE)
	`ASSERT_NEXT(a_holdoff_restart, clk, arst_n, adv && (result.safety_error != hvpc_pkg::SAFE_NONE), holdoff_q == '0)
	`ASSERT_NEXT(a_precharge_restart, clk, arst_n, adv && (state_q.mode == hvpc_pkg::MODE_IDLE) && (state_nxt.mode == hvpc_pkg::MODE_PRE), pre_q == '0)

endmodule
